[hdl/palette_indexed_blit_defines.svh]
// Assertion macros used by the blitter top module.
`ifndef PALETTE_INDEXED_BLIT_DEFINES_SVH
`define PALETTE_INDEXED_BLIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PIB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pib_pkg.sv]
package pib_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int OFFSET_BITS   = 20;

  localparam int INDEX_W = 8;
  localparam int COLOR_W = 16;
  localparam int DIM_W   = 12;
  localparam int ORG_W   = 11;
  localparam int CNT_W   = 11;
  localparam int START_W = ORG_W + DIM_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_STRIDE  = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_ORIGIN_X     = 3'd3,
    REG_ORIGIN_Y     = 3'd4
  } pib_reg_t;

  typedef enum logic {
    ACT_PAL_WRITE = 1'b0,
    ACT_PIXEL     = 1'b1
  } pib_action_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic                   last;
  } pib_pos_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hdl/pib_ifs.sv]
interface pib_src_if import pib_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [INDEX_W-1:0] color_index;
  logic [COLOR_W-1:0] entry_color;

  modport source (output valid, action, color_index, entry_color, input ready);
  modport sink (input valid, action, color_index, entry_color, output ready);
endinterface

interface pib_dst_if import pib_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] pixel_offset;
  logic [COLOR_W-1:0]     pixel_color;
  logic                   frame_last;

  modport source (output valid, pixel_offset, pixel_color, frame_last, input ready);
  modport sink (input valid, pixel_offset, pixel_color, frame_last, output ready);
endinterface

interface pib_cfg_if import pib_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/palette_indexed_blit.sv]
// Palette blitter: 8-bit index in, 16-bit color and framebuffer offset out.
// Throughput: one item per cycle, palette writes and pixels alike, unless held off by busy or output back-pressure.
// A pixel passes through the palette read register and then the output register.
// Reset: counters and offset clear, registers take their defaults, palette undefined.
// Input is held off after reset and after each register write, while derived values settle.
`include "palette_indexed_blit_defines.svh"

module palette_indexed_blit import pib_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pib_src_if.sink   src,
  pib_dst_if.source dst,
  pib_cfg_if.sink   cfg
);

  logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rd_data;

  pib_pos_t cur_pos;
  pib_pos_t s1_pos;
  logic     s1_valid;
  logic     s1_in_range;
  logic     busy;

  logic                   out_valid;
  logic [OFFSET_BITS-1:0] out_offset;
  logic [COLOR_W-1:0]     out_color;
  logic                   out_last;

  logic src_acc;
  logic pix_acc;
  logic wr_acc;
  logic idx_in_range;
  logic s1_adv;

  pib_offset_gen u_offset_gen (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (pix_acc),
    .pos  (cur_pos),
    .busy (busy)
  );

  assign s1_adv       = !out_valid || dst.ready;
  assign src.ready    = !busy && (!s1_valid || s1_adv);
  assign src_acc      = src.valid && src.ready;
  assign pix_acc      = src_acc && (src.action == ACT_PIXEL);
  assign wr_acc       = src_acc && (src.action == ACT_PAL_WRITE);
  assign idx_in_range = 32'(src.color_index) < PALETTE_DEPTH;

  // write and read both land at request acceptance, so a read sees every earlier write
  always_ff @(posedge clk) begin
    if (wr_acc && idx_in_range) begin
      palette_mem[src.color_index[PAL_AW-1:0]] <= src.entry_color;
    end
    if (pix_acc) begin
      rd_data <= palette_mem[src.color_index[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pos      <= cur_pos;
      s1_in_range <= idx_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_offset <= s1_pos.offset;
      out_color  <= s1_in_range ? rd_data : '0;
      out_last   <= s1_pos.last;
    end
  end

  assign dst.valid        = out_valid;
  assign dst.pixel_offset = out_offset;
  assign dst.pixel_color  = out_color;
  assign dst.frame_last   = out_last;

  `PIB_ASSERT_NOW(a_s1_from_pixel, s1_valid && !$past(s1_valid), $past(pix_acc), "s1 filled without pixel request")
  `PIB_ASSERT_NEXT(a_cfg_holds_input, cfg.valid && cfg.ready, !src.ready, "request taken right after register write")
  `PIB_ASSERT_NOW(a_no_overrun, s1_valid && out_valid && !dst.ready, !src.ready, "request taken while pipeline full")

endmodule

[hdl/pib_offset_gen.sv]
module pib_offset_gen import pib_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pib_cfg_if.sink    cfg,
  input  logic       step,
  output pib_pos_t   pos,
  output logic       busy
);

  logic [DIM_W-1:0] dest_stride;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [ORG_W-1:0] origin_x;
  logic [ORG_W-1:0] origin_y;

  logic [DIM_W-1:0]       width_eff;
  logic [DIM_W-1:0]       height_eff;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] row_skip;
  logic                   cfg_hold;

  logic [CNT_W-1:0]       column_count;
  logic [CNT_W-1:0]       row_count;
  logic [OFFSET_BITS-1:0] next_offset;

  logic [START_W-1:0]     start_raw;
  logic                   frame_first;
  logic [OFFSET_BITS-1:0] cur_offset;
  logic [DIM_W-1:0]       column_inc;
  logic [DIM_W-1:0]       row_inc;
  logic                   column_end;
  logic                   row_end;
  logic                   cfg_acc;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_stride  <= DIM_W'(320);
      image_width  <= DIM_W'(320);
      image_height <= DIM_W'(200);
      origin_x     <= ORG_W'(0);
      origin_y     <= ORG_W'(20);
    end else if (cfg_acc) begin
      unique case (cfg.index)
        REG_DEST_STRIDE:  dest_stride  <= cfg.data[DIM_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[DIM_W-1:0];
        REG_ORIGIN_X:     origin_x     <= cfg.data[ORG_W-1:0];
        REG_ORIGIN_Y:     origin_y     <= cfg.data[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off all input, pixels and palette writes, while derived values settle after a register write or reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= 1'b1;
    end else begin
      cfg_hold <= cfg_acc;
    end
  end

  assign start_raw = START_W'(origin_y) * START_W'(dest_stride) + START_W'(origin_x);

  always_ff @(posedge clk) begin
    width_eff    <= clamp_dim(image_width);
    height_eff   <= clamp_dim(image_height);
    start_offset <= OFFSET_BITS'(start_raw);
    row_skip     <= OFFSET_BITS'(dest_stride) - OFFSET_BITS'(clamp_dim(image_width))
                    + OFFSET_BITS'(1);
  end

  assign busy        = cfg_hold;
  assign frame_first = (column_count == '0) && (row_count == '0);
  assign cur_offset  = frame_first ? start_offset : next_offset;
  assign column_inc  = {1'b0, column_count} + DIM_W'(1);
  assign row_inc     = {1'b0, row_count} + DIM_W'(1);
  assign column_end  = column_inc >= width_eff;
  assign row_end     = row_inc >= height_eff;

  assign pos.offset = cur_offset;
  assign pos.last   = column_end && row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      next_offset  <= '0;
    end else if (step) begin
      next_offset <= cur_offset + (column_end ? row_skip : OFFSET_BITS'(1));
      if (column_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_inc[CNT_W-1:0];
      end else begin
        column_count <= column_inc[CNT_W-1:0];
      end
    end
  end

endmodule
